// ===== rtl/core/dvc_pkg.sv =====
package dvc_pkg;

	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned CONT_BIT   = 7;
	localparam logic [6:0]  GROUP_MASK = 7'h7F;
	localparam logic [2:0]  MAX_GROUPS = 3'd5;

	// Register index of the one configuration register
	localparam logic REG_DIRECTION = 1'b0;

	// Direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [31:0] position;
		logic [7:0]  code_byte;
		logic        list_start;
		logic        list_end;
	} dvc_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] out_position;
		logic        last;
		logic        error;
	} dvc_out_t;

	// One classified job between front and back: a delta to split into
	// groups, or a finished position to send out as is.
	typedef struct packed {
		logic        mode;
		logic [31:0] data;
		logic        err;
	} dvc_job_t;

endpackage

// ===== rtl/core/dvc_front.sv =====
module dvc_front import dvc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     dir,
	input  logic     accept,
	input  dvc_in_t  item,
	output logic     job_push,
	output dvc_job_t job
);

	logic [31:0] prev_q;
	logic [31:0] sum_q;
	logic [31:0] part_q;
	logic [2:0]  gc_q;
	logic        ov_q;

	logic [31:0] prev_b;
	logic [31:0] sum_b;
	logic [31:0] part_b;
	logic [2:0]  gc_b;
	logic        ov_b;
	logic [6:0]  grp;
	logic [31:0] grp_shift;
	logic [31:0] part_n;
	logic [2:0]  gc_n;
	logic        ov_n;
	logic [31:0] sum_n;
	logic        term;

	always_comb begin
		prev_b = item.list_start ? '0 : prev_q;
		sum_b  = item.list_start ? '0 : sum_q;
		part_b = item.list_start ? '0 : part_q;
		gc_b   = item.list_start ? '0 : gc_q;
		ov_b   = item.list_start ? 1'b0 : ov_q;
		grp    = item.code_byte[6:0] & GROUP_MASK;

		// Place the group at 7*count; the fifth group keeps only 4 bits
		unique case (gc_b)
			3'd0: grp_shift = {25'b0, grp};
			3'd1: grp_shift = {18'b0, grp, 7'b0};
			3'd2: grp_shift = {11'b0, grp, 14'b0};
			3'd3: grp_shift = {4'b0, grp, 21'b0};
			3'd4: grp_shift = {grp[3:0], 28'b0};
			default: grp_shift = '0;
		endcase

		if (gc_b < MAX_GROUPS) begin
			part_n = part_b | grp_shift;
			gc_n   = gc_b + 3'd1;
			ov_n   = ov_b;
		end else begin
			part_n = part_b;
			gc_n   = gc_b;
			ov_n   = 1'b1;
		end
		term  = !item.code_byte[CONT_BIT] || item.list_end;
		sum_n = sum_b + part_n;

		job.mode = dir;
		if (dir == DIR_ENCODE) begin
			job.data = item.position - prev_b;
			job.err  = item.position < prev_b;
			job_push = accept;
		end else begin
			job.data = sum_n;
			job.err  = ov_n;
			job_push = accept && term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
			part_q <= '0;
			gc_q   <= '0;
			ov_q   <= 1'b0;
		end else if (accept) begin
			if (dir == DIR_ENCODE) begin
				prev_q <= item.position;
			end else if (term) begin
				sum_q  <= sum_n;
				part_q <= '0;
				gc_q   <= '0;
				ov_q   <= 1'b0;
			end else begin
				sum_q  <= sum_b;
				part_q <= part_n;
				gc_q   <= gc_n;
				ov_q   <= ov_n;
			end
		end
	end

endmodule

// ===== rtl/core/dvc_queue.sv =====
module dvc_queue import dvc_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  dvc_job_t wr_job,
	output logic     full,
	input  logic     rd,
	output logic     nonempty,
	output dvc_job_t rd_job
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dvc_job_t        mem_q [DEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/dvc_back.sv =====
module dvc_back import dvc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_avail,
	input  dvc_job_t job_in,
	output logic     job_take,
	output logic     empty,
	input  logic     pop,
	output dvc_out_t result
);

	logic        job_vld_q;
	dvc_job_t    job_q;
	logic        out_vld_q;
	dvc_out_t    out_q;

	logic [31:0] rem;
	logic        cont;
	logic        done;
	logic        out_load;
	dvc_out_t    res_n;

	always_comb begin
		rem  = job_q.data >> GROUP_BITS;
		cont = (job_q.mode == DIR_ENCODE) && (rem != '0);
		done = !cont;

		res_n.error = job_q.err;
		if (job_q.mode == DIR_ENCODE) begin
			res_n.out_byte     = {cont, job_q.data[6:0] & GROUP_MASK};
			res_n.out_position = '0;
			res_n.last         = !cont;
		end else begin
			res_n.out_byte     = '0;
			res_n.out_position = job_q.data;
			res_n.last         = 1'b0;
		end

		out_load = job_vld_q && (!out_vld_q || pop);
		job_take = job_avail && (!job_vld_q || (out_load && done));
	end

	assign empty  = !out_vld_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_n;
		end
		if (job_take) begin
			job_q <= job_in;
		end else if (out_load && cont) begin
			job_q.data <= rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (job_take) begin
				job_vld_q <= 1'b1;
			end else if (out_load && done) begin
				job_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/delta_varint_codec_unit.sv =====
// Delta + LEB128 varint posting-list codec. With direction = 0 each pushed
// position has the previous position of its list subtracted (mod 2^32) and
// comes out as 1 to 5 bytes, low group first, bit 7 set on all but the final
// byte, which carries last; error marks a position below its predecessor and
// is repeated on every byte of that varint. With direction = 1 each pushed
// item is one code byte; a varint that ends (bit 7 clear, or list_end) adds
// into the running sum and one position comes out, with error set when the
// varint ran past five bytes. list_start restarts the list state of the mode
// in use. Rate: input takes one item per cycle while the job queue has room;
// output gives one transfer per cycle while popped, so an encode position
// holds the output until its bytes (1 to 5) are out and a decoded varint
// takes one input item per byte. The byte splitter in the back end is the
// limit for encode; the QUEUE_DEPTH job queue absorbs multi-byte bursts.
// Items pass the job queue, job register and output register. Direction is
// written over APB at address 0 and should only change while the codec is idle.
module delta_varint_codec_unit import dvc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic        push,
	output logic        full,
	input  dvc_in_t     item,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output dvc_out_t    result,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic     dir_q;
	logic     accept;
	logic     job_push;
	dvc_job_t job_f;
	logic     q_full;
	logic     q_nonempty;
	logic     q_take;
	dvc_job_t job_b;
	logic     cfg_wr;

	// Configuration register: index is paddr[2], only index 0 exists
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
		end else if (cfg_wr && (paddr[2] == REG_DIRECTION)) begin
			dir_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, dir_q} : '0;

	// Front: accepts a transfer whenever the job queue has room
	assign full   = q_full;
	assign accept = push && !q_full;

	dvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dir      (dir_q),
		.accept   (accept),
		.item     (item),
		.job_push (job_push),
		.job      (job_f)
	);

	dvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (job_push),
		.wr_job   (job_f),
		.full     (q_full),
		.rd       (q_take),
		.nonempty (q_nonempty),
		.rd_job   (job_b)
	);

	// Back: one result per cycle into the output register while it is empty or popped
	dvc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (q_nonempty),
		.job_in    (job_b),
		.job_take  (q_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// A job is never written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && q_full))
		else $error("job queue overflow");

	// A continued byte is never the final one
	a_cont_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.out_byte[7]) |-> !result.last)
		else $error("continued byte marked last");

	// A final encode byte never carries a position
	a_last_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.last) |-> (result.out_position == '0))
		else $error("encode result carries a position");

	// A taken job is always backed by a queue entry
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_nonempty)
		else $error("job taken from empty queue");

endmodule

// ===== test/tb_delta_varint_codec_unit.sv =====
module tb_delta_varint_codec_unit;
	import dvc_pkg::*;

	// Register map: direction is register 0 at byte address 0. Index one has
	// nothing behind it, writes there must leave direction alone.
	localparam logic [2:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED  = {~REG_DIRECTION, 2'b00};

	localparam int WATCHDOG_LIMIT = 1000; // cycles with no transfer on either side
	localparam int SETTLE_CYCLES  = 6;    // covers a push still in flight through the queue and back end
	localparam int MAX_REPORTS    = 10;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// One line of the directed table: either an item to push or a register
	// write. Items with typed_ok set carry their expected transfer inline.
	typedef struct {
		row_kind_t kind;
		dvc_in_t   in;
		bit        typed_ok;
		dvc_out_t  typed;
		logic [2:0]  addr;
		logic [31:0] data;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	dvc_in_t     item;
	logic        empty;
	logic        pop = 1'b0;
	dvc_out_t    result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Expected-transfer override for the directed rows, set along with item
	bit       fixed_due;
	dvc_out_t fixed_code;

	// Codec state as the testbench sees it
	logic        dir_cfg;
	logic [31:0] prev_pos;
	logic [31:0] run_sum;
	logic [31:0] part_val;
	logic [2:0]  grp_cnt;
	logic        overlong;

	dvc_out_t  pending_codes[$];   // transfers still owed by the codec, oldest first
	stim_row_t steps[$];

	int bad_cnt;
	int stalled;
	int tx_quiet;
	int rx_quiet;
	int rx_wait;

	always #4 clk = ~clk;

	delta_varint_codec_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Idle length for either side: mostly none or a few cycles, now and then
	// a long one, and occasional quiet stretches with no idling at all.
	function automatic int idle_len(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet = $urandom_range(8, 30);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	function automatic stim_row_t item_row(logic [31:0] pos, logic [7:0] cb, bit st, bit en);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		r.kind = ROW_ITEM;
		r.in.position = pos;
		r.in.code_byte = cb;
		r.in.list_start = st;
		r.in.list_end = en;
		return r;
	endfunction

	function automatic stim_row_t fixed_row(logic [31:0] pos, logic [7:0] cb, bit st, bit en,
			logic [7:0] ob, logic [31:0] op, bit lst, bit err);
		stim_row_t r;
		r = item_row(pos, cb, st, en);
		r.typed_ok = 1'b1;
		r.typed.out_byte = ob;
		r.typed.out_position = op;
		r.typed.last = lst;
		r.typed.error = err;
		return r;
	endfunction

	function automatic stim_row_t write_row(logic [2:0] a, logic [31:0] d);
		stim_row_t r;
		r = '{kind: ROW_WRITE, default: '0};
		r.kind = ROW_WRITE;
		r.addr = a;
		r.data = d;
		return r;
	endfunction

	function automatic void add_step(stim_row_t r);
		steps = {steps, r};
	endfunction

	task automatic note_bad(string msg);
		bad_cnt++;
		if (bad_cnt <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// Works out what one accepted item owes: 1..5 varint bytes when encoding,
	// zero or one position when decoding.
	task automatic predict_codes(dvc_in_t it);
		logic [31:0] delta;
		logic        err;
		dvc_out_t    r;
		if (dir_cfg == DIR_ENCODE) begin
			if (it.list_start)
				prev_pos = '0;
			err = it.position < prev_pos;
			delta = it.position - prev_pos; // wraps on a descending position
			prev_pos = it.position;
			do begin
				r = '0;
				r.out_byte = {1'b0, delta[6:0]};
				r.error = err;
				delta = delta >> GROUP_BITS;
				if (delta != 0)
					r.out_byte[CONT_BIT] = 1'b1;
				else
					r.last = 1'b1;
				pending_codes = {pending_codes, r};
			end while (!r.last);
		end else begin
			if (it.list_start) begin
				run_sum = '0;
				part_val = '0;
				grp_cnt = '0;
				overlong = 1'b0;
			end
			// fifth group: the shift by 28 drops its upper three bits
			if (grp_cnt < MAX_GROUPS) begin
				part_val |= 32'(it.code_byte[6:0]) << (GROUP_BITS * grp_cnt);
				grp_cnt++;
			end else begin
				overlong = 1'b1;
			end
			if (!it.code_byte[CONT_BIT] || it.list_end) begin
				run_sum += part_val;
				r = '0;
				r.out_position = run_sum;
				r.error = overlong;
				pending_codes = {pending_codes, r};
				part_val = '0;
				grp_cnt = '0;
				overlong = 1'b0;
			end
		end
	endtask

	// Monitor: everything is sampled at the rising edge, inputs were set up on
	// the falling edge before. Results are checked before the new item is
	// predicted, though the latency keeps the two apart anyway.
	always @(posedge clk) begin
		dvc_out_t want;
		int       n0;
		if (arst_n) begin
			stalled++;
			if (pop && !empty) begin
				stalled = 0;
				if (pending_codes.size() == 0) begin
					note_bad($sformatf("unexpected transfer: byte %02h pos %08h last %0b err %0b",
						result.out_byte, result.out_position, result.last, result.error));
				end else begin
					want = pending_codes.pop_front();
					if (result.out_byte !== want.out_byte ||
							result.out_position !== want.out_position ||
							result.last !== want.last || result.error !== want.error)
						note_bad($sformatf({"mismatch: want byte %02h pos %08h last %0b err %0b,",
							" got byte %02h pos %08h last %0b err %0b"},
							want.out_byte, want.out_position, want.last, want.error,
							result.out_byte, result.out_position, result.last, result.error));
				end
			end
			if (push && !full) begin
				stalled = 0;
				n0 = pending_codes.size();
				predict_codes(item);
				// directed rows with a typed answer replace what was predicted;
				// the state update still stands
				if (fixed_due) begin
					while (pending_codes.size() > n0)
						void'(pending_codes.pop_back());
					pending_codes = {pending_codes, fixed_code};
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION)
				dir_cfg = pwdata[0];
			if (stalled >= WATCHDOG_LIMIT) begin
				$display("tb_delta_varint_codec_unit NOT OK");
				$finish;
			end
		end
	end

	// Receiver side: pop stalls at random, changes on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_wait > 0) begin
			pop <= 1'b0;
			rx_wait--;
		end else begin
			rx_wait = idle_len(rx_quiet);
			pop <= (rx_wait == 0);
		end
	end

	// Push one item, with a random gap in front of it. Entered and left on a
	// falling edge; push stays high when the next item follows without a gap.
	task automatic send(dvc_in_t it, bit typed_ok, dvc_out_t typed);
		int gap;
		gap = idle_len(tx_quiet);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		fixed_due <= typed_ok;
		fixed_code <= typed;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Stop pushing and wait until every owed transfer is out, then a few more
	// cycles for a trailing item that owes nothing.
	task automatic settle();
		push <= 1'b0;
		while (pending_codes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write, and for the direction register a read back right after it
	task automatic write_reg(logic [2:0] a, logic [31:0] d);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		if (a == ADDR_DIRECTION) begin
			pwrite <= 1'b0;
			penable <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			rd = prdata;
			if (rd !== {31'b0, d[0]})
				note_bad($sformatf("direction read back: want %08h got %08h",
					{31'b0, d[0]}, rd));
			@(negedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Encode traffic: lists of ascending positions with deltas of every
	// byte count, a few descending or wild positions, and list flags that
	// mostly sit where they belong.
	task automatic run_encode_lists(int n_items);
		int          sent;
		int          len;
		int          r;
		logic [31:0] cur;
		logic [63:0] span;
		dvc_in_t     it;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 10);
			cur = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
			for (int i = 0; i < len; i++) begin
				if (i > 0) begin
					r = $urandom_range(0, 99);
					span = {32'b0, cur} + ({32'b0, $urandom} &
						((64'd1 << $urandom_range(0, 32)) - 1));
					if (r < 8)
						cur = $urandom_range(0, cur);
					else if (r < 12)
						cur = $urandom;
					else
						cur = span[32] ? 32'hFFFF_FFFF : span[31:0];
				end
				it.position = cur;
				it.code_byte = $urandom;
				it.list_start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
				it.list_end = (i == len - 1) ? ($urandom_range(0, 9) != 0) :
					($urandom_range(0, 19) == 0);
				send(it, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Decode traffic: lists of well-formed varints of random length, mixed
	// with overlong ones, unfinished ones cut off by list_end, and raw bytes.
	task automatic run_decode_lists(int n_items);
		int          sent;
		int          nvar;
		int          kind;
		int          nb;
		logic [31:0] v;
		logic [7:0]  cb;
		logic [7:0]  code_seq[$];
		dvc_in_t     it;
		sent = 0;
		while (sent < n_items) begin
			code_seq.delete();
			nvar = $urandom_range(1, 6);
			for (int k = 0; k < nvar; k++) begin
				kind = $urandom_range(0, 99);
				v = 32'({32'b0, $urandom} & ((64'd1 << $urandom_range(0, 32)) - 1));
				if (kind < 12) begin
					nb = $urandom_range(6, 8);
					for (int j = 0; j < nb - 1; j++)
						code_seq = {code_seq, 8'h80 | 8'($urandom_range(0, 127))};
					code_seq = {code_seq, 8'($urandom_range(0, 127))};
				end else if (kind < 20 && k == nvar - 1) begin
					nb = $urandom_range(1, 4);
					for (int j = 0; j < nb; j++)
						code_seq = {code_seq, 8'h80 | 8'($urandom_range(0, 127))};
				end else if (kind < 25) begin
					code_seq = {code_seq, 8'($urandom)};
				end else begin
					nb = 0;
					do begin
						cb = {1'b0, v[6:0]};
						v = v >> GROUP_BITS;
						nb++;
						if (v != 0)
							cb[CONT_BIT] = 1'b1;
						else if (nb == 5 && $urandom_range(0, 3) == 0)
							cb[6:4] = 3'($urandom_range(1, 7)); // bits that do not fit
						code_seq = {code_seq, cb};
					end while (v != 0);
				end
			end
			foreach (code_seq[j]) begin
				it.position = $urandom;
				it.code_byte = code_seq[j];
				it.list_start = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
				it.list_end = (j == code_seq.size() - 1) ? ($urandom_range(0, 9) != 0) :
					($urandom_range(0, 29) == 0);
				send(it, 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fixed_due = 1'b0;
		fixed_code = '0;
		dir_cfg = DIR_ENCODE;
		prev_pos = '0;
		run_sum = '0;
		part_val = '0;
		grp_cnt = '0;
		overlong = 1'b0;
		bad_cnt = 0;
		stalled = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		rx_wait = 0;

		// Directed table. Encode right out of reset (direction resets to 0).
		add_step(fixed_row(32'h0000_0000, 8'hFF, 1, 0, 8'h00, '0, 1, 0));
		add_step(fixed_row(32'h0000_007F, 8'h00, 0, 0, 8'h7F, '0, 1, 0));
		add_step(item_row(32'h0000_00FF, 8'hAA, 0, 0));     // two-byte delta
		add_step(item_row(32'hFFFF_FFFF, 8'h55, 1, 0));     // widest delta, five bytes
		add_step(fixed_row(32'h0000_0000, 8'h00, 0, 0, 8'h01, '0, 1, 1)); // descending
		add_step(fixed_row(32'h0000_0010, 8'hFF, 0, 1, 8'h10, '0, 1, 0)); // list end
		add_step(item_row(32'h8000_0000, 8'h80, 1, 1));
		// decode
		add_step(write_row(ADDR_DIRECTION, 32'(DIR_DECODE)));
		add_step(fixed_row(32'hFFFF_FFFF, 8'h05, 1, 0, 8'h00, 32'h5, 0, 0));
		add_step(fixed_row(32'h0000_0000, 8'h7F, 0, 0, 8'h00, 32'h84, 0, 0));
		add_step(item_row(32'hFFFF_FFFF, 8'h80, 1, 0));
		add_step(item_row(32'h0000_0000, 8'h01, 0, 0));
		// continued byte flushed by list_end
		add_step(fixed_row(32'h0000_0000, 8'hFF, 1, 1, 8'h00, 32'h7F, 0, 0));
		// overlong varint: five full groups, a sixth, then the terminator
		add_step(item_row(32'h0000_0000, 8'hFF, 1, 0));
		repeat (5) add_step(item_row(32'h0000_0000, 8'hFF, 0, 0));
		add_step(item_row(32'h0000_0000, 8'h00, 0, 0));
		add_step(item_row(32'h0000_0000, 8'h80, 0, 1));
		add_step(fixed_row(32'hFFFF_FFFF, 8'h00, 1, 0, 8'h00, 32'h0, 0, 0));
		// write to an empty slot must not flip the direction
		add_step(write_row(ADDR_UNMAPPED, 32'h0000_0000));
		add_step(fixed_row(32'h0000_0000, 8'h03, 0, 0, 8'h00, 32'h3, 0, 0));
		// back to encode: the encoder's previous position survived decode
		add_step(write_row(ADDR_DIRECTION, 32'(DIR_ENCODE)));
		add_step(item_row(32'h0000_0001, 8'h00, 0, 0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_WRITE) begin
				settle();
				write_reg(steps[i].addr, steps[i].data);
			end else begin
				send(steps[i].in, steps[i].typed_ok, steps[i].typed);
			end
		end

		// Random part, direction alternating; the pause between the two encode
		// halves lets the result side run completely dry.
		settle();
		run_encode_lists(25);
		settle();
		run_encode_lists(25);
		settle();
		write_reg(ADDR_DIRECTION, 32'hFFFF_FFFF);
		run_decode_lists(50);
		settle();
		write_reg(ADDR_DIRECTION, 32'hFFFF_FFFE);
		run_encode_lists(50);
		settle();
		write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		write_reg(ADDR_DIRECTION, 32'(DIR_DECODE));
		run_decode_lists(50);
		settle();

		if (bad_cnt == 0 && pending_codes.size() == 0) begin
			$display("tb_delta_varint_codec_unit OK");
		end else begin
			$display("tb_delta_varint_codec_unit NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dvc_pkg.sv
rtl/core/dvc_front.sv
rtl/core/dvc_queue.sv
rtl/core/dvc_back.sv
rtl/core/delta_varint_codec_unit.sv
test/tb_delta_varint_codec_unit.sv
